// ===== rtl/core/mecanum_odometry_integrator_defines.svh =====
// Assertion macros shared by the odometry integrator RTL.
`ifndef MECANUM_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MOI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MOI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MOI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MOI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/moi_pkg.sv =====
// Shared types and constants of the mecanum odometry integrator.
`timescale 1ns / 1ps
`default_nettype none
package moi_pkg;

   // CORDIC iteration count (8 to 24) and its counter width
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W = 5;

   // divider operand widths
   localparam int DIVIDEND_W = 50;
   localparam int DIVISOR_W = 20;

   // numeric constants
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
   localparam logic [29:0] BAM_PER_RAD_Q16 = 30'd683565276;

   localparam logic [29:0] ATAN_Q30 [24] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
   };

   // slot numbers of the angle advance loop
   localparam logic [2:0] WHEEL_LAST = 3'd3;
   localparam logic [2:0] YAW_SLOT = 3'd4;

   // configuration register indexes
   localparam logic REG_WHEEL_RADIUS = 1'b0;
   localparam logic REG_OFFSET_SUM = 1'b1;

   typedef enum logic [5:0] {
      DP_NOP, DP_LOAD, DP_MUL_CW, DP_SCALE_W, DP_DIV_WHEEL, DP_SAVE_WHEEL,
      DP_MUL_VX, DP_SAVE_VX, DP_MUL_VY, DP_SAVE_VY, DP_MUL_WZ, DP_DIV_WZ,
      DP_SAVE_WZ, DP_MUL_DX, DP_SAVE_DX, DP_MUL_DY, DP_SAVE_DY, DP_MUL_Z,
      DP_SAVE_Z, DP_CORDIC_STEP, DP_CORDIC_FIX, DP_MUL_XC, DP_MUL_YS,
      DP_MUL_XS, DP_MUL_YC, DP_ACC_SET, DP_ACC_SUB, DP_ACC_ADD, DP_POS_X,
      DP_POS_Y, DP_MUL_RATE, DP_SAVE_RAD, DP_MUL_BAM, DP_APPLY, DP_PUBLISH
   } dp_op_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_V_MUL, ST_V_SCALE, ST_V_DIV, ST_V_WAIT, ST_V_SAVE,
      ST_T_MUL_VX, ST_T_SAVE_VX, ST_T_MUL_VY, ST_T_SAVE_VY, ST_T_MUL_WZ,
      ST_T_DIV_WZ, ST_T_WAIT_WZ, ST_T_SAVE_WZ, ST_T_MUL_DX, ST_T_SAVE_DX,
      ST_T_MUL_DY, ST_T_SAVE_DY, ST_T_MUL_Z, ST_T_SAVE_Z, ST_T_CORDIC,
      ST_T_CORDIC_FIX, ST_T_MUL_XC, ST_T_ACC_XC, ST_T_MUL_YS, ST_T_ACC_YS,
      ST_T_POS_X, ST_T_MUL_XS, ST_T_ACC_XS, ST_T_MUL_YC, ST_T_ACC_YC,
      ST_T_POS_Y, ST_A_MUL_RATE, ST_A_SAVE_RAD, ST_A_MUL_BAM, ST_A_APPLY,
      ST_T_PUBLISH
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic [2:0] idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic cordic_last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/mecanum_odometry_integrator.sv =====
// Top level of the mecanum odometry integrator: register port and core.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_odometry_integrator_defines.svh"
// One request at a time. A velocity request (op 0) does one multiply, then
// four bit-serial divisions by the wheel radius, one per wheel. A tick
// request (op 1) runs through the yaw rate division, the CORDIC iterations
// and the single shared multiplier; it may hold in its publish step while
// a previous response is still being stalled. The response register lets
// a new request enter while the last response waits. The response shows
// the updated pose and heading with the wheel angles as they were before
// the tick. Registers: 0 wheel_radius (byte 0), 1 wheel_offset_sum
// (byte 4); zero values act as one.
module mecanum_odometry_integrator (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic req_op,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic signed [31:0] req_yaw_rate,
   input  wire logic [15:0] req_tick_interval,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0] rsp_heading,
   output logic [15:0] rsp_angle_front_left,
   output logic [15:0] rsp_angle_rear_left,
   output logic [15:0] rsp_angle_front_right,
   output logic [15:0] rsp_angle_rear_right,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [2:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [15:0] wheel_radius_ff, wheel_radius_in;
   logic [17:0] offset_sum_ff, offset_sum_in;
   logic csr_wr;
   moi_pkg::ctrl_cmd_type cmd;
   moi_pkg::dp_status_type status;

   // configuration registers
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      wheel_radius_in = wheel_radius_ff;
      offset_sum_in = offset_sum_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            moi_pkg::REG_WHEEL_RADIUS: wheel_radius_in = csr_pwdata[15:0];
            moi_pkg::REG_OFFSET_SUM: offset_sum_in = csr_pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_radius_ff <= 16'd2458;
         offset_sum_ff <= 18'd13107;
      end else begin
         wheel_radius_ff <= wheel_radius_in;
         offset_sum_ff <= offset_sum_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == moi_pkg::REG_WHEEL_RADIUS) ?
                       {16'd0, wheel_radius_ff} : {14'd0, offset_sum_ff};
   assign csr_pready = 1'b1;

   moi_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_op(req_op),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   moi_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .radius(wheel_radius_ff),
      .offset_sum(offset_sum_ff),
      .req_vel_x(req_vel_x),
      .req_vel_y(req_vel_y),
      .req_yaw_rate(req_yaw_rate),
      .req_tick_interval(req_tick_interval),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_heading(rsp_heading),
      .rsp_angle_front_left(rsp_angle_front_left),
      .rsp_angle_rear_left(rsp_angle_rear_left),
      .rsp_angle_front_right(rsp_angle_front_right),
      .rsp_angle_rear_right(rsp_angle_rear_right)
   );

   // an accepted request makes the block busy in the next cycle
   `MOI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted but block not busy")
   // a response is only published mid-tick, never from idle
   `MOI_ASSERT_IMPLY(a_publish_busy, clock, reset, $rose(rsp_valid), req_stall, "response rose while idle")
   // a radius write lands in the register
   `MOI_ASSERT_NEXT(a_radius_write, clock, reset, csr_wr && !csr_paddr[2], wheel_radius_ff == $past(csr_pwdata[15:0]), "radius write lost")
endmodule
`default_nettype wire

// ===== rtl/core/moi_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module moi_divider (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [moi_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [moi_pkg::DIVISOR_W-1:0] divisor,
   output logic [moi_pkg::DIVIDEND_W-1:0] quotient,
   output logic done
);
   localparam int CNT_W = $clog2(moi_pkg::DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(moi_pkg::DIVIDEND_W - 1);

   logic [moi_pkg::DIVIDEND_W-1:0] num_ff, num_in;
   logic [moi_pkg::DIVISOR_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [moi_pkg::DIVISOR_W:0] shifted, trial;

   // one shift and trial subtract per cycle
   always_comb begin
      shifted = {rem_ff, num_ff[moi_pkg::DIVIDEND_W-1]};
      trial = shifted - {1'b0, dsr_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[moi_pkg::DIVISOR_W]) begin
            rem_in = trial[moi_pkg::DIVISOR_W-1:0];
            num_in = {num_ff[moi_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[moi_pkg::DIVISOR_W-1:0];
            num_in = {num_ff[moi_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = num_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== rtl/core/moi_datapath.sv =====
// Datapath: kinematics, CORDIC rotation, integration and result register.
`timescale 1ns / 1ps
`default_nettype none
module moi_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire moi_pkg::ctrl_cmd_type cmd,
   output moi_pkg::dp_status_type status,
   input  wire logic [15:0] radius,
   input  wire logic [17:0] offset_sum,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic signed [31:0] req_yaw_rate,
   input  wire logic [15:0] req_tick_interval,
   input  wire logic rsp_stall,
   output logic rsp_valid,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0] rsp_heading,
   output logic [15:0] rsp_angle_front_left,
   output logic [15:0] rsp_angle_rear_left,
   output logic [15:0] rsp_angle_front_right,
   output logic [15:0] rsp_angle_rear_right
);
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7FFFFFFF;
      else if (v < S32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // latched request and architectural state
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, wz_ff, wz_in;
   logic [15:0] dt_ff, dt_in;
   logic signed [31:0] rate_ff [4];
   logic signed [31:0] rate_in [4];
   logic [15:0] angle_ff [4];
   logic [15:0] angle_in [4];
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [15:0] yaw_ff, yaw_in;
   // work registers
   logic signed [33:0] wzs_ff, wzs_in;
   logic signed [31:0] bvx_ff, bvx_in, bvy_ff, bvy_in, bwz_ff, bwz_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [33:0] cs_ff, cs_in, sn_ff, sn_in;
   logic flip_ff, flip_in, neg_ff, neg_in;
   logic [moi_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [32:0] rad_ff, rad_in;
   logic signed [68:0] prod_ff, prod_in;
   // result register
   logic rv_ff, rv_in;
   logic signed [31:0] opx_ff, opx_in, opy_ff, opy_in;
   logic [15:0] ohd_ff, ohd_in;
   logic [15:0] oang_ff [4];
   logic [15:0] oang_in [4];

   // combinational helpers
   logic [15:0] r_eff;
   logic [17:0] c_eff;
   logic signed [34:0] mul_a;
   logic signed [33:0] mul_b;
   logic mul_en;
   logic signed [34:0] e0, e1, e2, e3, sum_vx, sum_vy, sum_wz;
   logic signed [35:0] wheel_num, wvx, wvy, wws;
   logic [35:0] wheel_mag;
   logic [68:0] prod_mag;
   logic div_start, div_done;
   logic [moi_pkg::DIVIDEND_W-1:0] div_dividend, div_quot;
   logic [moi_pkg::DIVISOR_W-1:0] div_divisor;
   logic signed [31:0] div_sat;
   logic signed [16:0] a17, a_adj;
   logic flip_now;
   logic signed [33:0] shx, shy, atan_v;
   logic signed [31:0] rate_sel;
   logic [15:0] dang;
   logic [1:0] widx;

   assign r_eff = (radius == 16'd0) ? 16'd1 : radius;
   assign c_eff = (offset_sum == 18'd0) ? 18'd1 : offset_sum;
   assign widx = cmd.idx[1:0];

   // forward kinematics sums
   always_comb begin
      e0 = {{3{rate_ff[0][31]}}, rate_ff[0]};
      e1 = {{3{rate_ff[1][31]}}, rate_ff[1]};
      e2 = {{3{rate_ff[2][31]}}, rate_ff[2]};
      e3 = {{3{rate_ff[3][31]}}, rate_ff[3]};
      sum_vx = e0 + e1 + e2 + e3;
      sum_vy = e1 + e2 - e0 - e3;
      sum_wz = e2 + e3 - e0 - e1;
   end

   // inverse kinematics numerator for the wheel selected by idx
   always_comb begin
      wvx = {{4{vx_ff[31]}}, vx_ff};
      wvy = {{4{vy_ff[31]}}, vy_ff};
      wws = {{2{wzs_ff[33]}}, wzs_ff};
      case (widx)
         2'd0: wheel_num = wvx - wvy - wws;
         2'd1: wheel_num = wvx + wvy - wws;
         2'd2: wheel_num = wvx + wvy + wws;
         default: wheel_num = wvx - wvy + wws;
      endcase
      wheel_mag = wheel_num[35] ? 36'(-wheel_num) : 36'(wheel_num);
      prod_mag = prod_ff[68] ? 69'(-prod_ff) : 69'(prod_ff);
   end

   // signed saturation of the divider quotient
   always_comb begin
      if (!neg_ff) begin
         if (div_quot > moi_pkg::DIVIDEND_W'(32'h7FFFFFFF)) div_sat = 32'sh7FFFFFFF;
         else div_sat = div_quot[31:0];
      end else begin
         if (div_quot > moi_pkg::DIVIDEND_W'(32'h80000000)) div_sat = 32'sh80000000;
         else div_sat = 32'(~div_quot[31:0] + 32'd1);
      end
   end

   // heading folded into the right half plane
   always_comb begin
      a17 = {yaw_ff[15], yaw_ff};
      flip_now = 1'b0;
      a_adj = a17;
      if (a17 > 17'sd16384) begin
         a_adj = a17 - 17'sd32768;
         flip_now = 1'b1;
      end else if (a17 < -17'sd16384) begin
         a_adj = a17 + 17'sd32768;
         flip_now = 1'b1;
      end
   end

   // CORDIC shifted terms
   assign shx = cy_ff >>> iter_ff;
   assign shy = cx_ff >>> iter_ff;
   assign atan_v = {4'b0000, moi_pkg::ATAN_Q30[iter_ff]};

   assign rate_sel = (cmd.idx == moi_pkg::YAW_SLOT) ? bwz_ff : rate_ff[widx];
   assign dang = prod_ff[47:32];

   // shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         moi_pkg::DP_MUL_CW: begin
            mul_a = {17'd0, c_eff};
            mul_b = {{2{wz_ff[31]}}, wz_ff};
         end
         moi_pkg::DP_MUL_VX: begin
            mul_a = sum_vx;
            mul_b = {18'd0, r_eff};
         end
         moi_pkg::DP_MUL_VY: begin
            mul_a = sum_vy;
            mul_b = {18'd0, r_eff};
         end
         moi_pkg::DP_MUL_WZ: begin
            mul_a = sum_wz;
            mul_b = {18'd0, r_eff};
         end
         moi_pkg::DP_MUL_DX: begin
            mul_a = {{3{bvx_ff[31]}}, bvx_ff};
            mul_b = {18'd0, dt_ff};
         end
         moi_pkg::DP_MUL_DY: begin
            mul_a = {{3{bvy_ff[31]}}, bvy_ff};
            mul_b = {18'd0, dt_ff};
         end
         moi_pkg::DP_MUL_Z: begin
            mul_a = {{18{a_adj[16]}}, a_adj};
            mul_b = {1'b0, moi_pkg::TWO_PI_Q30};
         end
         moi_pkg::DP_MUL_XC: begin
            mul_a = {{3{dx_ff[31]}}, dx_ff};
            mul_b = cs_ff;
         end
         moi_pkg::DP_MUL_YS: begin
            mul_a = {{3{dy_ff[31]}}, dy_ff};
            mul_b = sn_ff;
         end
         moi_pkg::DP_MUL_XS: begin
            mul_a = {{3{dx_ff[31]}}, dx_ff};
            mul_b = sn_ff;
         end
         moi_pkg::DP_MUL_YC: begin
            mul_a = {{3{dy_ff[31]}}, dy_ff};
            mul_b = cs_ff;
         end
         moi_pkg::DP_MUL_RATE: begin
            mul_a = {{3{rate_sel[31]}}, rate_sel};
            mul_b = {18'd0, dt_ff};
         end
         moi_pkg::DP_MUL_BAM: begin
            mul_a = {{2{rad_ff[32]}}, rad_ff};
            mul_b = {4'd0, moi_pkg::BAM_PER_RAD_Q16};
         end
         default: mul_en = 1'b0;
      endcase
      prod_in = mul_en ? mul_a * mul_b : prod_ff;
   end

   // register updates per command
   always_comb begin
      vx_in = vx_ff;
      vy_in = vy_ff;
      wz_in = wz_ff;
      dt_in = dt_ff;
      rate_in = rate_ff;
      angle_in = angle_ff;
      posx_in = posx_ff;
      posy_in = posy_ff;
      yaw_in = yaw_ff;
      wzs_in = wzs_ff;
      bvx_in = bvx_ff;
      bvy_in = bvy_ff;
      bwz_in = bwz_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      cs_in = cs_ff;
      sn_in = sn_ff;
      flip_in = flip_ff;
      neg_in = neg_ff;
      iter_in = iter_ff;
      acc_in = acc_ff;
      rad_in = rad_ff;
      opx_in = opx_ff;
      opy_in = opy_ff;
      ohd_in = ohd_ff;
      oang_in = oang_ff;
      rv_in = rv_ff && rsp_stall;
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = '0;
      case (cmd.op)
         moi_pkg::DP_LOAD: begin
            vx_in = req_vel_x;
            vy_in = req_vel_y;
            wz_in = req_yaw_rate;
            dt_in = req_tick_interval;
         end
         moi_pkg::DP_SCALE_W: wzs_in = prod_ff[49:16];
         moi_pkg::DP_DIV_WHEEL: begin
            div_start = 1'b1;
            div_dividend = {wheel_mag[33:0], 16'd0};
            div_divisor = {4'd0, r_eff};
            neg_in = wheel_num[35];
         end
         moi_pkg::DP_SAVE_WHEEL: rate_in[widx] = div_sat;
         moi_pkg::DP_SAVE_VX: bvx_in = sat32({{13{prod_ff[68]}}, prod_ff[68:18]});
         moi_pkg::DP_SAVE_VY: bvy_in = sat32({{13{prod_ff[68]}}, prod_ff[68:18]});
         moi_pkg::DP_DIV_WZ: begin
            div_start = 1'b1;
            div_dividend = prod_mag[49:0];
            div_divisor = {c_eff, 2'b00};
            neg_in = prod_ff[68];
         end
         moi_pkg::DP_SAVE_WZ: bwz_in = div_sat;
         moi_pkg::DP_SAVE_DX: dx_in = prod_ff[47:16];
         moi_pkg::DP_SAVE_DY: dy_in = prod_ff[47:16];
         moi_pkg::DP_MUL_Z: begin
            cx_in = {4'd0, moi_pkg::INV_GAIN_Q30};
            cy_in = '0;
            iter_in = '0;
            flip_in = flip_now;
         end
         moi_pkg::DP_SAVE_Z: cz_in = prod_ff[49:16];
         moi_pkg::DP_CORDIC_STEP: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - shx;
               cy_in = cy_ff + shy;
               cz_in = cz_ff - atan_v;
            end else begin
               cx_in = cx_ff + shx;
               cy_in = cy_ff - shy;
               cz_in = cz_ff + atan_v;
            end
            iter_in = iter_ff + 1'b1;
         end
         moi_pkg::DP_CORDIC_FIX: begin
            cs_in = flip_ff ? -cx_ff : cx_ff;
            sn_in = flip_ff ? -cy_ff : cy_ff;
         end
         moi_pkg::DP_ACC_SET: acc_in = prod_ff[67:0];
         moi_pkg::DP_ACC_SUB: acc_in = acc_ff - prod_ff[67:0];
         moi_pkg::DP_ACC_ADD: acc_in = acc_ff + prod_ff[67:0];
         moi_pkg::DP_POS_X:
            posx_in = sat32({{32{posx_ff[31]}}, posx_ff} + {{26{acc_ff[67]}}, acc_ff[67:30]});
         moi_pkg::DP_POS_Y:
            posy_in = sat32({{32{posy_ff[31]}}, posy_ff} + {{26{acc_ff[67]}}, acc_ff[67:30]});
         moi_pkg::DP_SAVE_RAD: rad_in = prod_ff[48:16];
         moi_pkg::DP_APPLY: begin
            if (cmd.idx == moi_pkg::YAW_SLOT) yaw_in = yaw_ff + dang;
            else angle_in[widx] = angle_ff[widx] + dang;
         end
         moi_pkg::DP_PUBLISH: begin
            rv_in = 1'b1;
            opx_in = posx_ff;
            opy_in = posy_ff;
            ohd_in = yaw_ff;
            oang_in = angle_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            rate_ff[i] <= '0;
            angle_ff[i] <= '0;
         end
         posx_ff <= '0;
         posy_ff <= '0;
         yaw_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         rate_ff <= rate_in;
         angle_ff <= angle_in;
         posx_ff <= posx_in;
         posy_ff <= posy_in;
         yaw_ff <= yaw_in;
         rv_ff <= rv_in;
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      wz_ff <= wz_in;
      dt_ff <= dt_in;
      wzs_ff <= wzs_in;
      bvx_ff <= bvx_in;
      bvy_ff <= bvy_in;
      bwz_ff <= bwz_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      cs_ff <= cs_in;
      sn_ff <= sn_in;
      flip_ff <= flip_in;
      neg_ff <= neg_in;
      iter_ff <= iter_in;
      acc_ff <= acc_in;
      rad_ff <= rad_in;
      prod_ff <= prod_in;
      opx_ff <= opx_in;
      opy_ff <= opy_in;
      ohd_ff <= ohd_in;
      oang_ff <= oang_in;
   end

   moi_divider u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(div_divisor),
      .quotient(div_quot),
      .done(div_done)
   );

   // status back to the controller
   assign status.div_done = div_done;
   assign status.cordic_last = (iter_ff == moi_pkg::ITER_W'(moi_pkg::CORDIC_STEPS - 1));
   assign status.out_free = !rv_ff || !rsp_stall;

   assign rsp_valid = rv_ff;
   assign rsp_pos_x = opx_ff;
   assign rsp_pos_y = opy_ff;
   assign rsp_heading = ohd_ff;
   assign rsp_angle_front_left = oang_ff[0];
   assign rsp_angle_rear_left = oang_ff[1];
   assign rsp_angle_front_right = oang_ff[2];
   assign rsp_angle_rear_right = oang_ff[3];
endmodule
`default_nettype wire

// ===== rtl/core/moi_ctrl.sv =====
// Sequencer that steps the datapath through velocity and tick requests.
`timescale 1ns / 1ps
`default_nettype none
module moi_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_op,
   output logic req_stall,
   input  wire moi_pkg::dp_status_type status,
   output moi_pkg::ctrl_cmd_type cmd
);
   moi_pkg::ctrl_state_type state_ff, state_in;
   logic [2:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= moi_pkg::ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd.op = moi_pkg::DP_NOP;
      cmd.idx = idx_ff;
      case (state_ff)
         moi_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op = moi_pkg::DP_LOAD;
               idx_in = '0;
               state_in = req_op ? moi_pkg::ST_T_MUL_VX : moi_pkg::ST_V_MUL;
            end
         end
         // velocity request: inverse kinematics, one division per wheel
         moi_pkg::ST_V_MUL: begin
            cmd.op = moi_pkg::DP_MUL_CW;
            state_in = moi_pkg::ST_V_SCALE;
         end
         moi_pkg::ST_V_SCALE: begin
            cmd.op = moi_pkg::DP_SCALE_W;
            state_in = moi_pkg::ST_V_DIV;
         end
         moi_pkg::ST_V_DIV: begin
            cmd.op = moi_pkg::DP_DIV_WHEEL;
            state_in = moi_pkg::ST_V_WAIT;
         end
         moi_pkg::ST_V_WAIT: if (status.div_done) state_in = moi_pkg::ST_V_SAVE;
         moi_pkg::ST_V_SAVE: begin
            cmd.op = moi_pkg::DP_SAVE_WHEEL;
            if (idx_ff == moi_pkg::WHEEL_LAST) begin
               state_in = moi_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 3'd1;
               state_in = moi_pkg::ST_V_DIV;
            end
         end
         // tick request: body velocities
         moi_pkg::ST_T_MUL_VX: begin
            cmd.op = moi_pkg::DP_MUL_VX;
            state_in = moi_pkg::ST_T_SAVE_VX;
         end
         moi_pkg::ST_T_SAVE_VX: begin
            cmd.op = moi_pkg::DP_SAVE_VX;
            state_in = moi_pkg::ST_T_MUL_VY;
         end
         moi_pkg::ST_T_MUL_VY: begin
            cmd.op = moi_pkg::DP_MUL_VY;
            state_in = moi_pkg::ST_T_SAVE_VY;
         end
         moi_pkg::ST_T_SAVE_VY: begin
            cmd.op = moi_pkg::DP_SAVE_VY;
            state_in = moi_pkg::ST_T_MUL_WZ;
         end
         moi_pkg::ST_T_MUL_WZ: begin
            cmd.op = moi_pkg::DP_MUL_WZ;
            state_in = moi_pkg::ST_T_DIV_WZ;
         end
         moi_pkg::ST_T_DIV_WZ: begin
            cmd.op = moi_pkg::DP_DIV_WZ;
            state_in = moi_pkg::ST_T_WAIT_WZ;
         end
         moi_pkg::ST_T_WAIT_WZ: if (status.div_done) state_in = moi_pkg::ST_T_SAVE_WZ;
         moi_pkg::ST_T_SAVE_WZ: begin
            cmd.op = moi_pkg::DP_SAVE_WZ;
            state_in = moi_pkg::ST_T_MUL_DX;
         end
         // displacement over the interval
         moi_pkg::ST_T_MUL_DX: begin
            cmd.op = moi_pkg::DP_MUL_DX;
            state_in = moi_pkg::ST_T_SAVE_DX;
         end
         moi_pkg::ST_T_SAVE_DX: begin
            cmd.op = moi_pkg::DP_SAVE_DX;
            state_in = moi_pkg::ST_T_MUL_DY;
         end
         moi_pkg::ST_T_MUL_DY: begin
            cmd.op = moi_pkg::DP_MUL_DY;
            state_in = moi_pkg::ST_T_SAVE_DY;
         end
         moi_pkg::ST_T_SAVE_DY: begin
            cmd.op = moi_pkg::DP_SAVE_DY;
            state_in = moi_pkg::ST_T_MUL_Z;
         end
         // sine and cosine of the heading
         moi_pkg::ST_T_MUL_Z: begin
            cmd.op = moi_pkg::DP_MUL_Z;
            state_in = moi_pkg::ST_T_SAVE_Z;
         end
         moi_pkg::ST_T_SAVE_Z: begin
            cmd.op = moi_pkg::DP_SAVE_Z;
            state_in = moi_pkg::ST_T_CORDIC;
         end
         moi_pkg::ST_T_CORDIC: begin
            cmd.op = moi_pkg::DP_CORDIC_STEP;
            if (status.cordic_last) state_in = moi_pkg::ST_T_CORDIC_FIX;
         end
         moi_pkg::ST_T_CORDIC_FIX: begin
            cmd.op = moi_pkg::DP_CORDIC_FIX;
            state_in = moi_pkg::ST_T_MUL_XC;
         end
         // rotate into the world frame and integrate
         moi_pkg::ST_T_MUL_XC: begin
            cmd.op = moi_pkg::DP_MUL_XC;
            state_in = moi_pkg::ST_T_ACC_XC;
         end
         moi_pkg::ST_T_ACC_XC: begin
            cmd.op = moi_pkg::DP_ACC_SET;
            state_in = moi_pkg::ST_T_MUL_YS;
         end
         moi_pkg::ST_T_MUL_YS: begin
            cmd.op = moi_pkg::DP_MUL_YS;
            state_in = moi_pkg::ST_T_ACC_YS;
         end
         moi_pkg::ST_T_ACC_YS: begin
            cmd.op = moi_pkg::DP_ACC_SUB;
            state_in = moi_pkg::ST_T_POS_X;
         end
         moi_pkg::ST_T_POS_X: begin
            cmd.op = moi_pkg::DP_POS_X;
            state_in = moi_pkg::ST_T_MUL_XS;
         end
         moi_pkg::ST_T_MUL_XS: begin
            cmd.op = moi_pkg::DP_MUL_XS;
            state_in = moi_pkg::ST_T_ACC_XS;
         end
         moi_pkg::ST_T_ACC_XS: begin
            cmd.op = moi_pkg::DP_ACC_SET;
            state_in = moi_pkg::ST_T_MUL_YC;
         end
         moi_pkg::ST_T_MUL_YC: begin
            cmd.op = moi_pkg::DP_MUL_YC;
            state_in = moi_pkg::ST_T_ACC_YC;
         end
         moi_pkg::ST_T_ACC_YC: begin
            cmd.op = moi_pkg::DP_ACC_ADD;
            state_in = moi_pkg::ST_T_POS_Y;
         end
         moi_pkg::ST_T_POS_Y: begin
            cmd.op = moi_pkg::DP_POS_Y;
            idx_in = moi_pkg::YAW_SLOT;
            state_in = moi_pkg::ST_A_MUL_RATE;
         end
         // angle advance: heading first, then the four wheels
         moi_pkg::ST_A_MUL_RATE: begin
            cmd.op = moi_pkg::DP_MUL_RATE;
            state_in = moi_pkg::ST_A_SAVE_RAD;
         end
         moi_pkg::ST_A_SAVE_RAD: begin
            cmd.op = moi_pkg::DP_SAVE_RAD;
            state_in = moi_pkg::ST_A_MUL_BAM;
         end
         moi_pkg::ST_A_MUL_BAM: begin
            cmd.op = moi_pkg::DP_MUL_BAM;
            state_in = moi_pkg::ST_A_APPLY;
         end
         moi_pkg::ST_A_APPLY: begin
            cmd.op = moi_pkg::DP_APPLY;
            if (idx_ff == moi_pkg::YAW_SLOT) begin
               state_in = moi_pkg::ST_T_PUBLISH;
            end else if (idx_ff == moi_pkg::WHEEL_LAST) begin
               state_in = moi_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 3'd1;
               state_in = moi_pkg::ST_A_MUL_RATE;
            end
         end
         // result carries wheel angles from before this tick
         moi_pkg::ST_T_PUBLISH: begin
            if (status.out_free) begin
               cmd.op = moi_pkg::DP_PUBLISH;
               idx_in = '0;
               state_in = moi_pkg::ST_A_MUL_RATE;
            end
         end
         default: state_in = moi_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != moi_pkg::ST_IDLE);
endmodule
`default_nettype wire

// ===== sim/tb_mecanum_odometry_integrator.sv =====
// Self-checking testbench for the mecanum odometry integrator: kinematics, CORDIC and pose.
`timescale 1ns / 1ps
`default_nettype none
module tb_mecanum_odometry_integrator;

   localparam logic OP_VELOCITY = 1'b0;
   localparam logic OP_TICK = 1'b1;
   localparam logic [2:0] ADDR_WHEEL_RADIUS = 3'd0;
   localparam logic [2:0] ADDR_OFFSET_SUM = 3'd4;
   localparam int SETTLE_CYCLES = 300;
   localparam int ROT_STEPS = 16;
   localparam longint ROT_GAIN = 64'd652032874;
   localparam longint FULL_TURN_Q30 = 64'd6746518852;
   localparam longint BAM_SCALE = 64'd683565276;
   localparam longint ARCTAN [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
   };

   typedef struct {
      logic op;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] wz;
      logic [15:0] dt;
   } motion_req_t;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [15:0] hdg;
      logic [15:0] ang [4];
   } pose_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic signed [31:0] req_vel_x = '0;
   logic signed [31:0] req_vel_y = '0;
   logic signed [31:0] req_yaw_rate = '0;
   logic [15:0] req_tick_interval = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic [15:0] rsp_heading;
   logic [15:0] rsp_angle_front_left;
   logic [15:0] rsp_angle_rear_left;
   logic [15:0] rsp_angle_front_right;
   logic [15:0] rsp_angle_rear_right;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   mecanum_odometry_integrator dut (.*);

   // clock and reset
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // predictor state
   longint radius_cfg = 2458;
   longint offset_cfg = 13107;
   longint wheel_rate_q [4] = '{0, 0, 0, 0};
   logic [15:0] wheel_ang_q [4] = '{0, 0, 0, 0};
   longint pose_x_q = 0;
   longint pose_y_q = 0;
   logic [15:0] yaw_q = '0;

   motion_req_t pending_reqs [$];
   pose_t expected_poses [$];
   int fail_count = 0;
   bit req_taken = 1'b0;
   bit pause_sender = 1'b0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [15:0] advance_angle(logic [15:0] ang, longint rate, longint dt);
      longint rad;
      longint d;
      rad = (rate * dt) >>> 16;
      d = (rad * BAM_SCALE) >>> 32;
      return ang + d[15:0];
   endfunction

   // CORDIC rotation of the heading, folded into +-quarter turn
   function automatic void heading_sincos(logic [15:0] bam, output longint c,
                                          output longint s);
      longint a;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit flip;
      a = longint'($signed(bam));
      flip = 1'b0;
      x = ROT_GAIN;
      y = 0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1'b1;
      end
      z = (a * FULL_TURN_Q30) >>> 16;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // kinematics and odometry update for one accepted request
   function automatic void predict_odometry(motion_req_t q);
      longint r;
      longint c;
      longint vx;
      longint vy;
      longint wz;
      longint dx;
      longint dy;
      longint cs;
      longint sn;
      longint dt;
      longint fl;
      longint rl;
      longint fr;
      longint rr;
      pose_t p;
      r = (radius_cfg != 0) ? radius_cfg : 1;
      c = (offset_cfg != 0) ? offset_cfg : 1;
      fl = wheel_rate_q[0]; rl = wheel_rate_q[1];
      fr = wheel_rate_q[2]; rr = wheel_rate_q[3];
      if (q.op == OP_VELOCITY) begin
         vx = longint'(q.vx);
         vy = longint'(q.vy);
         wz = (c * longint'(q.wz)) >>> 16;
         wheel_rate_q[0] = sat32((vx - vy - wz) * 65536 / r);
         wheel_rate_q[1] = sat32((vx + vy - wz) * 65536 / r);
         wheel_rate_q[2] = sat32((vx + vy + wz) * 65536 / r);
         wheel_rate_q[3] = sat32((vx - vy + wz) * 65536 / r);
         return;
      end
      dt = longint'({48'd0, q.dt});
      vx = sat32((r * (fl + rl + fr + rr)) >>> 18);
      vy = sat32((r * (-fl + rl + fr - rr)) >>> 18);
      wz = sat32((r * (-fl - rl + fr + rr)) / (4 * c));
      dx = (vx * dt) >>> 16;
      dy = (vy * dt) >>> 16;
      heading_sincos(yaw_q, cs, sn);
      pose_x_q = sat32(pose_x_q + ((dx * cs - dy * sn) >>> 30));
      pose_y_q = sat32(pose_y_q + ((dx * sn + dy * cs) >>> 30));
      yaw_q = advance_angle(yaw_q, wz, dt);
      p.px = pose_x_q[31:0];
      p.py = pose_y_q[31:0];
      p.hdg = yaw_q;
      for (int i = 0; i < 4; i++) begin
         p.ang[i] = wheel_ang_q[i];
         wheel_ang_q[i] = advance_angle(wheel_ang_q[i], wheel_rate_q[i], dt);
      end
      expected_poses.push_back(p);
   endfunction

   // request driver: bursts with random gaps
   int burst_left = 8;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !pause_sender) begin
            req_valid <= 1'b1;
            req_op <= pending_reqs[0].op;
            req_vel_x <= pending_reqs[0].vx;
            req_vel_y <= pending_reqs[0].vy;
            req_yaw_rate <= pending_reqs[0].wz;
            req_tick_interval <= pending_reqs[0].dt;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern: none, random, or mostly stalled
   int stall_mode = 0;
   int stall_age = 0;
   always @(negedge clock) begin
      if (stall_age >= 200) begin
         stall_age <= 0;
         stall_mode <= $urandom_range(0, 2);
      end else begin
         stall_age <= stall_age + 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // monitor: check responses, then predict from accepted requests
   always @(posedge clock) begin
      motion_req_t q;
      pose_t p;
      logic [15:0] got_ang [4];
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               $error("unexpected response pos_x=%0d pos_y=%0d", rsp_pos_x, rsp_pos_y);
               fail_count++;
            end else begin
               p = expected_poses.pop_front();
               got_ang = '{rsp_angle_front_left, rsp_angle_rear_left,
                           rsp_angle_front_right, rsp_angle_rear_right};
               if (rsp_pos_x !== p.px) begin
                  $error("pos_x expected %0d got %0d", p.px, rsp_pos_x);
                  fail_count++;
               end
               if (rsp_pos_y !== p.py) begin
                  $error("pos_y expected %0d got %0d", p.py, rsp_pos_y);
                  fail_count++;
               end
               if (rsp_heading !== p.hdg) begin
                  $error("heading expected %0d got %0d", p.hdg, rsp_heading);
                  fail_count++;
               end
               for (int i = 0; i < 4; i++) begin
                  if (got_ang[i] !== p.ang[i]) begin
                     $error("wheel angle %0d expected %0d got %0d", i, p.ang[i], got_ang[i]);
                     fail_count++;
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            q = pending_reqs.pop_front();
            predict_odometry(q);
         end
      end
   end

   function automatic logic signed [31:0] rand_speed();
      if ($urandom_range(0, 6) == 0) return $urandom();
      return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
   endfunction

   function automatic motion_req_t velocity_req(logic signed [31:0] vx, logic signed [31:0] vy,
                                                logic signed [31:0] wz);
      motion_req_t q;
      q.op = OP_VELOCITY; q.vx = vx; q.vy = vy; q.wz = wz; q.dt = 16'($urandom());
      return q;
   endfunction

   function automatic motion_req_t tick_req(logic [15:0] dt);
      motion_req_t q;
      q.op = OP_TICK; q.vx = $urandom(); q.vy = $urandom(); q.wz = $urandom(); q.dt = dt;
      return q;
   endfunction

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_WHEEL_RADIUS) radius_cfg = data[15:0];
      else if (addr == ADDR_OFFSET_SUM) offset_cfg = data[17:0];
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_poses.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0)
            pending_reqs.push_back(velocity_req(rand_speed(), rand_speed(), rand_speed()));
         else if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back(tick_req(16'($urandom())));
         else
            pending_reqs.push_back(tick_req(16'($urandom_range(0, 4000))));
      end
   endtask

   // stimulus phases across register settings
   initial begin
      logic [31:0] radii [5];
      logic [31:0] offsets [5];
      radii = '{32'd2458, 32'd1, 32'd65535, 32'd0, 32'd0};
      offsets = '{32'd13107, 32'd1, 32'd131072, 32'd0, 32'd0};
      radii[4] = $urandom_range(1, 65535);
      offsets[4] = $urandom_range(1, 131072);
      @(negedge reset);
      // directed: extremes of every field, zero and full tick intervals
      pending_reqs.push_back(tick_req(16'd0));
      pending_reqs.push_back(velocity_req(32'sd65536, 32'sd0, 32'sd0));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(tick_req(16'd1000));
      pending_reqs.push_back(velocity_req(32'sd0, 32'sd0, 32'sd200000));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(velocity_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(velocity_req(32'sh80000000, 32'sh80000000, 32'sh80000000));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(velocity_req(32'sh7fffffff, 32'sh80000000, 32'sh00000000));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(tick_req(16'd32768));
      pending_reqs.push_back(velocity_req(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
      pending_reqs.push_back(tick_req(16'd65535));
      pending_reqs.push_back(velocity_req(32'sd0, 32'sd0, 32'sd0));
      pending_reqs.push_back(tick_req(16'd12345));
      for (int ph = 0; ph < 5; ph++) begin
         queue_random(260);
         if (ph == 1) begin
            // hold the sender until the block has drained
            while (pending_reqs.size() > 130) @(posedge clock);
            pause_sender = 1'b1;
            while (req_valid || expected_poses.size() > 0) @(posedge clock);
            repeat (SETTLE_CYCLES) @(posedge clock);
            pause_sender = 1'b0;
         end
         wait_idle();
         csr_write(ADDR_WHEEL_RADIUS, radii[ph]);
         csr_write(ADDR_OFFSET_SUM, offsets[ph]);
      end
      queue_random(60);
      wait_idle();
      if (fail_count == 0) begin
         $display("mecanum_odometry_integrator regression: pass");
      end else begin
         $display("mecanum_odometry_integrator regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #6000000;
      $display("mecanum_odometry_integrator regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
